// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
// No dependencies; imported by every other file of the block.
`default_nettype none

package bpc_pkg;

   localparam int SAMPLE_W = 10;
   localparam int THRESH_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // reset values of the configuration registers
   localparam logic [SAMPLE_W-1:0] SAMPLE_PERIOD_RST = SAMPLE_W'(50);
   localparam logic [THRESH_W-1:0] LONG_PRESS_RST = THRESH_W'(1000);
   localparam logic [THRESH_W-1:0] MULTI_WINDOW_RST = THRESH_W'(500);

   localparam logic [1:0] TRIPLE_COUNT = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_PERIOD = 2'd0,
      CSR_LONG_PRESS = 2'd1,
      CSR_MULTI_WINDOW = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_SINGLE = 2'd1,
      EV_LONG = 2'd2,
      EV_TRIPLE = 2'd3
   } event_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_period;
      logic [THRESH_W-1:0] long_press_ticks;
      logic [THRESH_W-1:0] multi_press_window;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/button_press_classifier.sv =====
// Button press classifier: each req beat is one millisecond tick carrying the raw
// active-low button level; each tick yields exactly one rsp beat with the event
// code (none, single, long, triple) and the debounced pressed flag. One beat is
// taken per clock while rsp is not stalled: an input register feeds a single stage
// of counter updates and compares that loads the result register, so the
// sustained rate is one tick per clock while rsp is not stalled.
// Depends on bpc_pkg, bpc_csr and bpc_track.
`default_nettype none

module button_press_classifier import bpc_pkg::*; #(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_pin_level,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_event_code,
   output logic                       rsp_pressed
);

   cfg_type   cfg;
   event_type ev;
   logic      pressed;

   logic      in_vld_ff, in_vld_in;
   logic      pin_ff;
   logic      rsp_vld_ff, rsp_vld_in;
   logic [1:0] event_ff;
   logic      pressed_ff;
   logic      out_ready;
   logic      step;
   logic      req_beat;

   assign out_ready = !rsp_vld_ff || !rsp_stall;
   assign step = in_vld_ff && out_ready;
   assign req_stall = in_vld_ff && !out_ready;
   assign req_beat = req_valid && !req_stall;

   bpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bpc_track #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (step),
      .pin_level  (pin_ff),
      .event_code (ev),
      .pressed    (pressed)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_beat) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (step) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         pin_ff <= req_pin_level;
      end
      if (step) begin
         event_ff <= ev;
         pressed_ff <= pressed;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_event_code = event_ff;
   assign rsp_pressed = pressed_ff;

   a_step_loads_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_vld_ff)
      else $error("processed tick did not reach the result register");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_stall |=> rsp_vld_ff && $stable(event_ff) && $stable(pressed_ff))
      else $error("stalled rsp beat changed");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("req stalled with nothing pending");

endmodule

`default_nettype wire

// ===== rtl/bpc_csr.sv =====
// Configuration register bank of the button press classifier.
// Depends on bpc_pkg for the register layout and index codes.
`default_nettype none

module bpc_csr import bpc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: cfg_in.sample_period = csr_write_data[SAMPLE_W-1:0];
            CSR_LONG_PRESS:    cfg_in.long_press_ticks = csr_write_data[THRESH_W-1:0];
            CSR_MULTI_WINDOW:  cfg_in.multi_press_window = csr_write_data[THRESH_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period <= SAMPLE_PERIOD_RST;
         cfg_ff.long_press_ticks <= LONG_PRESS_RST;
         cfg_ff.multi_press_window <= MULTI_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/bpc_track.sv =====
// Debounce sampler, press/release timers and press classification.
// Depends on bpc_pkg; state advances one tick per step strobe.
`default_nettype none

module bpc_track import bpc_pkg::*; #(
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  cfg_type   cfg,
   input  wire logic step,
   input  wire logic pin_level,
   output event_type event_code,
   output logic      pressed
);

   localparam int CMP_W = (TIMER_WIDTH > THRESH_W) ? TIMER_WIDTH : THRESH_W;

   // sample timer stays below sample_period (max 1023) after every tick, or at zero
   // for a zero period, so its increment never wraps
   logic [SAMPLE_W-1:0]    sample_timer_ff, sample_timer_in;
   logic                   sampled_level_ff, sampled_level_in;
   logic [TIMER_WIDTH-1:0] press_timer_ff, press_timer_in;
   logic [TIMER_WIDTH-1:0] release_timer_ff, release_timer_in;
   logic [1:0]             press_count_ff, press_count_in;

   logic [SAMPLE_W-1:0]    sample_inc;
   logic [1:0]             count_inc;
   event_type              ev;

   always_comb begin
      sample_inc = sample_timer_ff + 1'b1;
      press_timer_in = (press_timer_ff == '1) ? press_timer_ff : press_timer_ff + 1'b1;
      release_timer_in = (release_timer_ff == '1) ? release_timer_ff
                                                  : release_timer_ff + 1'b1;
      sample_timer_in = sample_inc;
      sampled_level_in = sampled_level_ff;
      press_count_in = press_count_ff;
      count_inc = press_count_ff + 1'b1;
      ev = EV_NONE;

      if (sample_inc >= cfg.sample_period) begin
         sampled_level_in = pin_level;
         sample_timer_in = '0;
      end

      if (!sampled_level_in && sampled_level_ff) begin
         press_timer_in = '0;
      end else if (sampled_level_in && !sampled_level_ff) begin
         if (CMP_W'(press_timer_in) >= CMP_W'(cfg.long_press_ticks)) begin
            ev = EV_LONG;
            press_count_in = '0;
         end else if (CMP_W'(release_timer_in) < CMP_W'(cfg.multi_press_window)) begin
            press_count_in = count_inc;
            if (count_inc == TRIPLE_COUNT) begin
               ev = EV_TRIPLE;
               press_count_in = '0;
            end
         end else begin
            press_count_in = 2'd1;
         end
         release_timer_in = '0;
      end

      // lone press times out once the window has passed
      if (ev == EV_NONE && press_count_in == 2'd1 &&
          CMP_W'(release_timer_in) >= CMP_W'(cfg.multi_press_window)) begin
         ev = EV_SINGLE;
         press_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_timer_ff <= '0;
         sampled_level_ff <= 1'b1;
         press_timer_ff <= '0;
         release_timer_ff <= '0;
         press_count_ff <= '0;
      end else if (step) begin
         sample_timer_ff <= sample_timer_in;
         sampled_level_ff <= sampled_level_in;
         press_timer_ff <= press_timer_in;
         release_timer_ff <= release_timer_in;
         press_count_ff <= press_count_in;
      end
   end

   assign event_code = ev;
   assign pressed = !sampled_level_in;

   a_count_below_triple: assert property (@(posedge clock) disable iff (reset)
      press_count_ff != TRIPLE_COUNT)
      else $error("press count held the triple value");

   a_event_clears_count: assert property (@(posedge clock) disable iff (reset)
      step && ev != EV_NONE |=> press_count_ff == 2'd0)
      else $error("press count not cleared after an event");

   a_release_event_needs_press: assert property (@(posedge clock) disable iff (reset)
      step && (ev == EV_LONG || ev == EV_TRIPLE) |-> !sampled_level_ff)
      else $error("long or triple press without a prior pressed level");

endmodule

`default_nettype wire
